>>> hdl/lpcp_pkg.sv
// Package for the lidar point camera projection block.
// Holds register indexes, the register count, the default image size and the shared quotient width; depends on nothing.
package lpcp_pkg;

	// Configuration register indexes
	localparam logic [7:0] REG_P00_P01 = 8'd0;
	localparam logic [7:0] REG_P02_P03 = 8'd1;
	localparam logic [7:0] REG_P10_P11 = 8'd2;
	localparam logic [7:0] REG_P12_P13 = 8'd3;
	localparam logic [7:0] REG_P20_P21 = 8'd4;
	localparam logic [7:0] REG_P22_P23 = 8'd5;
	localparam logic [7:0] REG_IMAGE_WIDTH = 8'd6;
	localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd7;

	localparam int NUM_P_REGS = 6;
	localparam logic [14:0] DEFAULT_WIDTH = 15'd2448;
	localparam logic [14:0] DEFAULT_HEIGHT = 15'd2048;

	// Quotient bits produced by the divider: bit 16 flags overflow of 16 bits
	localparam int QUO_BITS = 17;

endpackage

>>> hdl/lpcp_front.sv
// Front part: registers the point, forms nine products, sums the three rows.
// Depends on lpcp_pkg.
module lpcp_front #(
	parameter int FRAC_BITS = 16,
	parameter int SUM_W = 50
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  accept,
	input  logic signed [31:0]    point_x,
	input  logic signed [31:0]    point_y,
	input  logic signed [31:0]    point_z,
	input  logic [63:0]           p_regs [lpcp_pkg::NUM_P_REGS],
	output logic                  sum_valid,
	output logic signed [SUM_W-1:0] sum_x,
	output logic signed [SUM_W-1:0] sum_y,
	output logic signed [SUM_W-1:0] sum_w
);
	import lpcp_pkg::*;

	logic                    v_s1, v_s2, v_s3;
	logic signed [31:0]      crd_s1 [3];
	logic signed [63:0]      prod_s2 [9];
	logic signed [SUM_W-1:0] sum_s3 [3];

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Point capture
	always_ff @(posedge clk) begin
		if (en && accept) begin
			crd_s1[0] <= point_x;
			crd_s1[1] <= point_y;
			crd_s1[2] <= point_z;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [SUM_W-1:0] term [3];
		logic signed [31:0]      tr;
		logic signed [SUM_W-1:0] tr_x;

		for (genvar j = 0; j < 3; j++) begin : g_col
			logic signed [31:0] coef;
			logic signed [63:0] shifted;
			if (j % 2 == 1) begin : g_hi
				assign coef = p_regs[r*2 + j/2][63:32];
			end else begin : g_lo
				assign coef = p_regs[r*2 + j/2][31:0];
			end

			// One 32x32 product per stage register
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s2[r*3+j] <= 64'(coef) * 64'(crd_s1[j]);
				end
			end

			// Arithmetic shift rounds toward minus infinity
			assign shifted = prod_s2[r*3+j] >>> FRAC_BITS;
			assign term[j] = shifted[SUM_W-1:0];
		end

		assign tr = p_regs[r*2 + 1][63:32];
		assign tr_x = {{(SUM_W-32){tr[31]}}, tr};

		always_ff @(posedge clk) begin
			if (en) begin
				sum_s3[r] <= term[0] + term[1] + term[2] + tr_x;
			end
		end
	end

	assign sum_valid = v_s3;
	assign sum_x = sum_s3[0];
	assign sum_y = sum_s3[1];
	assign sum_w = sum_s3[2];

endmodule

>>> hdl/lpcp_fifo.sv
// Two-entry queue between the front and back parts.
// Depends on nothing beyond its parameter.
module lpcp_fifo #(
	parameter int WIDTH = 150
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic             full
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push, do_pop;

	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign empty = (count_q == 2'd0);
	assign full = (count_q == 2'd2);
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> hdl/lpcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on lpcp_pkg for the quotient width.
module lpcp_div #(
	parameter int NW = 50
) (
	input  logic                          clk,
	input  logic [NW-1:0]                 num,
	input  logic [NW-1:0]                 den,
	output logic [lpcp_pkg::QUO_BITS-1:0] quo
);
	import lpcp_pkg::*;

	logic [NW-1:0]       rem_q [1:QUO_BITS];
	logic [NW-1:0]       den_q [1:QUO_BITS];
	logic [QUO_BITS-1:0] quo_q [1:QUO_BITS];

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
		localparam int K = QUO_BITS - 1 - i;
		localparam logic [QUO_BITS-1:0] BIT = QUO_BITS'(1) << K;
		logic [NW-1:0]          rem_c, den_c;
		logic [QUO_BITS-1:0]    quo_c;
		logic [NW+QUO_BITS-1:0] trial, rem_x;
		logic                   ge;

		if (i == 0) begin : g_first
			assign rem_c = num;
			assign den_c = den;
			assign quo_c = '0;
		end else begin : g_next
			assign rem_c = rem_q[i];
			assign den_c = den_q[i];
			assign quo_c = quo_q[i];
		end

		// Trial subtract of the shifted divisor
		assign trial = {{QUO_BITS{1'b0}}, den_c} << K;
		assign rem_x = {{QUO_BITS{1'b0}}, rem_c};
		assign ge = (rem_x >= trial);

		always_ff @(posedge clk) begin
			rem_q[i+1] <= ge ? (rem_c - trial[NW-1:0]) : rem_c;
			den_q[i+1] <= den_c;
			quo_q[i+1] <= ge ? (quo_c | BIT) : quo_c;
		end
	end

	assign quo = quo_q[QUO_BITS];

endmodule

>>> hdl/lpcp_back.sv
// Back part: magnitudes and signs, two divider pipelines, saturation and bounds.
// Depends on lpcp_pkg and lpcp_div.
module lpcp_back #(
	parameter int SUM_W = 50
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [SUM_W-1:0] sum_x,
	input  logic signed [SUM_W-1:0] sum_y,
	input  logic signed [SUM_W-1:0] sum_w,
	input  logic [14:0]             image_width,
	input  logic [14:0]             image_height,
	output logic                    done,
	output logic signed [15:0]      pixel_column,
	output logic signed [15:0]      pixel_row,
	output logic signed [31:0]      depth,
	output logic                    inside_image
);
	import lpcp_pkg::*;

	typedef struct packed {
		logic        valid;
		logic        neg_u;
		logic        neg_v;
		logic        w_zero;
		logic [31:0] depth;
	} side_t;

	side_t               side_q [0:QUO_BITS];
	side_t               side_d;
	logic [SUM_W-1:0]    mag_x_s0, mag_y_s0, mag_w_s0;
	logic [SUM_W-1:0]    mag_x, mag_y, mag_w;
	logic                fits32;
	logic [QUO_BITS-1:0] quo_u, quo_v;

	// Magnitudes, quotient signs and saturated depth
	assign mag_x = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
	assign mag_y = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
	assign mag_w = sum_w[SUM_W-1] ? SUM_W'(-sum_w) : SUM_W'(sum_w);
	assign fits32 = (&sum_w[SUM_W-1:31]) || !(|sum_w[SUM_W-1:31]);

	always_comb begin
		side_d.valid = in_valid;
		side_d.neg_u = (sum_x != '0) && (sum_x[SUM_W-1] != sum_w[SUM_W-1]);
		side_d.neg_v = (sum_y != '0) && (sum_y[SUM_W-1] != sum_w[SUM_W-1]);
		side_d.w_zero = (sum_w == '0);
		if (fits32) side_d.depth = sum_w[31:0];
		else if (sum_w[SUM_W-1]) side_d.depth = 32'h8000_0000;
		else side_d.depth = 32'h7FFF_FFFF;
	end

	always_ff @(posedge clk) begin
		mag_x_s0 <= mag_x;
		mag_y_s0 <= mag_y;
		mag_w_s0 <= mag_w;
	end

	// Sideband line kept in step with the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QUO_BITS; i++) side_q[i] <= '0;
		end else begin
			side_q[0] <= side_d;
			for (int i = 1; i <= QUO_BITS; i++) side_q[i] <= side_q[i-1];
		end
	end

	lpcp_div #(.NW(SUM_W)) u_div_u (
		.clk (clk),
		.num (mag_x_s0),
		.den (mag_w_s0),
		.quo (quo_u)
	);

	lpcp_div #(.NW(SUM_W)) u_div_v (
		.clk (clk),
		.num (mag_y_s0),
		.den (mag_w_s0),
		.quo (quo_v)
	);

	// Truncated quotient to 16-bit signed with saturation
	function automatic logic [15:0] sat_quo(input logic [QUO_BITS-1:0] q, input logic neg);
		logic ovf;
		logic [15:0] mag;
		ovf = q[QUO_BITS-1];
		mag = q[15:0];
		if (!neg) sat_quo = (ovf || mag[15]) ? 16'h7FFF : mag;
		else sat_quo = (ovf || mag > 16'h8000) ? 16'h8000 : 16'(-mag);
	endfunction

	side_t      fin;
	logic [15:0] col_c, row_c;
	logic        in_c;

	assign fin = side_q[QUO_BITS];
	assign col_c = fin.w_zero ? 16'h0000 : sat_quo(quo_u, fin.neg_u);
	assign row_c = fin.w_zero ? 16'h0000 : sat_quo(quo_v, fin.neg_v);
	assign in_c = !fin.w_zero && !fin.neg_u && !fin.neg_v
		&& !quo_u[QUO_BITS-1] && !quo_v[QUO_BITS-1]
		&& (quo_u[15:0] < {1'b0, image_width})
		&& (quo_v[15:0] < {1'b0, image_height});

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel_column <= col_c;
		pixel_row <= row_c;
		depth <= fin.depth;
		inside_image <= in_c;
	end

endmodule

>>> hdl/lidar_point_camera_projection.sv
// Top level of the lidar point camera projection block.
// Depends on lpcp_pkg, lpcp_front, lpcp_fifo and lpcp_back.
//
// Channel   Handshake                  Payload
// request   start / busy               point_x, point_y, point_z
// result    done (one-cycle strobe)    pixel_column, pixel_row, depth, inside_image
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One point per cycle while busy is low; from accept to done a point passes
// three front stages (capture, products, row sums), one queue slot, one
// magnitude stage, seventeen divider stages and the output register.
// Reset clears all valids and the queue; coefficients reset to zero.
// The back part always drains the queue, so busy rises only if it fills.
module lidar_point_camera_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               done,
	output logic signed [15:0] pixel_column,
	output logic signed [15:0] pixel_row,
	output logic signed [31:0] depth,
	output logic               inside_image,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import lpcp_pkg::*;

	localparam int SUM_W = 64 - FRAC_BITS + 2;
	localparam int LATENCY = 6 + QUO_BITS;

	logic [63:0] p_q [NUM_P_REGS];
	logic [14:0] width_q, height_q;
	logic        accept, en;
	logic        fifo_full, fifo_empty;
	logic        sum_valid;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_w;
	logic [3*SUM_W-1:0] q_out;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_P_REGS; i++) p_q[i] <= '0;
			width_q <= DEFAULT_WIDTH;
			height_q <= DEFAULT_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_P00_P01: p_q[0] <= cfg_data;
				REG_P02_P03: p_q[1] <= cfg_data;
				REG_P10_P11: p_q[2] <= cfg_data;
				REG_P12_P13: p_q[3] <= cfg_data;
				REG_P20_P21: p_q[4] <= cfg_data;
				REG_P22_P23: p_q[5] <= cfg_data;
				REG_IMAGE_WIDTH: width_q <= cfg_data[14:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Front stalls only while the queue is full
	assign en = !fifo_full;
	assign busy = fifo_full;
	assign accept = start && !busy;

	lpcp_front #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.accept    (accept),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.p_regs    (p_q),
		.sum_valid (sum_valid),
		.sum_x     (sum_x),
		.sum_y     (sum_y),
		.sum_w     (sum_w)
	);

	lpcp_fifo #(.WIDTH(3*SUM_W)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sum_valid && en),
		.push_data ({sum_x, sum_y, sum_w}),
		.pop       (!fifo_empty),
		.pop_data  (q_out),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	lpcp_back #(.SUM_W(SUM_W)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!fifo_empty),
		.sum_x        (q_out[3*SUM_W-1:2*SUM_W]),
		.sum_y        (q_out[2*SUM_W-1:SUM_W]),
		.sum_w        (q_out[SUM_W-1:0]),
		.image_width  (width_q),
		.image_height (height_q),
		.done         (done),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.depth        (depth),
		.inside_image (inside_image)
	);

	// Checks
	a_no_full: assert property (@(posedge clk) disable iff (!arst_n) !fifo_full)
		else $error("queue filled although the back part drains every cycle");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a request at the fixed latency");

	a_inside_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && inside_image) |-> (depth != 32'sd0))
		else $error("point flagged inside with zero depth");

endmodule
